FILE: design/cr422_pkg.sv
// shared types and constants for the 4:2:0 to 4:2:2 vertical chroma upsampler
// no dependencies
package cr422_pkg;

    localparam int SAMPLE_W = 8;
    localparam int TAPS     = 7;
    localparam int SUM_W    = 18;
    localparam int ROWS_W   = 2;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef sample_t [TAPS-1:0]  window_t;

    localparam logic signed [SUM_W-1:0] COEF_0    = 18'sd3;
    localparam logic signed [SUM_W-1:0] COEF_1    = -18'sd16;
    localparam logic signed [SUM_W-1:0] COEF_2    = 18'sd67;
    localparam logic signed [SUM_W-1:0] COEF_3    = 18'sd227;
    localparam logic signed [SUM_W-1:0] COEF_4    = -18'sd32;
    localparam logic signed [SUM_W-1:0] COEF_5    = 18'sd7;
    localparam logic signed [SUM_W-1:0] ROUND_OFS = 18'sd128;
    localparam int                      SHIFT     = 8;
    localparam logic signed [SUM_W-1:0] MAX_VAL   = 18'sd255;

    localparam logic [ROWS_W-1:0] ROWS_FULL = 2'd3;
    localparam logic [ROWS_W-1:0] LAST_STEP = 2'd3;

    typedef struct packed {
        sample_t in_sample;
        logic    column_start;
        logic    column_end;
    } in_item_t;

    typedef struct packed {
        sample_t out_sample;
        logic    odd_row;
        logic    run_end;
        logic    column_done;
    } out_item_t;

    typedef struct packed {
        logic fill;
        logic shift;
    } cell_ctrl_t;

endpackage

FILE: design/cr422_stream_if.sv
// valid/ready stream channel carrying one payload
// payload type is given at instantiation, usually from cr422_pkg
interface cr422_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/cr422_cell.sv
// one window cell: holds a sample row, fills or takes its neighbour's value
// depends on cr422_pkg
module cr422_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cr422_pkg::cell_ctrl_t ctrl,
    input  cr422_pkg::sample_t   fill_value,
    input  cr422_pkg::sample_t   neighbour,
    output cr422_pkg::sample_t   value
);

    cr422_pkg::sample_t value_reg;
    cr422_pkg::sample_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.fill)
        begin
            value_next = fill_value;
        end
        else if (ctrl.shift)
        begin
            value_next = neighbour;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

FILE: design/cr422_fir.sv
// 6-tap interpolation filter with rounding and clamp, taps mirrored for odd rows
// depends on cr422_pkg
module cr422_fir (
    input  cr422_pkg::window_t window,
    input  logic               odd,
    output cr422_pkg::sample_t result
);

    cr422_pkg::sample_t t0, t1, t2, t3, t4, t5;
    logic signed [cr422_pkg::SUM_W-1:0] p0, p1, p2, p3, p4, p5;
    logic signed [cr422_pkg::SUM_W-1:0] sum;
    logic signed [cr422_pkg::SUM_W-1:0] rnd;
    logic signed [cr422_pkg::SUM_W-1:0] shifted;

    localparam int PAD = cr422_pkg::SUM_W - cr422_pkg::SAMPLE_W;

    always_comb
    begin
        t0 = odd ? window[6] : window[0];
        t1 = odd ? window[5] : window[1];
        t2 = odd ? window[4] : window[2];
        t3 = window[3];
        t4 = odd ? window[2] : window[4];
        t5 = odd ? window[1] : window[5];

        p0 = $signed({{PAD{1'b0}}, t0}) * cr422_pkg::COEF_0;
        p1 = $signed({{PAD{1'b0}}, t1}) * cr422_pkg::COEF_1;
        p2 = $signed({{PAD{1'b0}}, t2}) * cr422_pkg::COEF_2;
        p3 = $signed({{PAD{1'b0}}, t3}) * cr422_pkg::COEF_3;
        p4 = $signed({{PAD{1'b0}}, t4}) * cr422_pkg::COEF_4;
        p5 = $signed({{PAD{1'b0}}, t5}) * cr422_pkg::COEF_5;

        sum     = p0 + p1 + p2 + p3 + p4 + p5;
        rnd     = sum + cr422_pkg::ROUND_OFS;
        shifted = rnd >>> cr422_pkg::SHIFT;

        if (rnd[cr422_pkg::SUM_W-1])
        begin
            result = '0;
        end
        else if (shifted > cr422_pkg::MAX_VAL)
        begin
            result = '1;
        end
        else
        begin
            result = shifted[cr422_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

FILE: design/chroma_420_to_422_vertical_upsampler.sv
// latency: once three rows are in, an accepted request starts the sequencer, which then
// registers its first result; a column end on a shorter column shifts before it emits
// throughput: one request per cycle while a column fills, then one per two results, taken
// as the second enters the one output register, which waits on out_ch.ready; a column-end
// request runs up to four steps, two results per emitting step; reset: rst_n asynchronous,
// not clearing out_item_reg; depends on cr422_pkg, cr422_stream_if, cr422_cell, cr422_fir
module chroma_420_to_422_vertical_upsampler (
    input  logic            clk,
    input  logic            rst_n,
    cr422_stream_if.sink    in_ch,
    cr422_stream_if.source  out_ch
);

    logic                          active_reg;
    logic                          half_reg;
    logic                          end_reg;
    logic [cr422_pkg::ROWS_W-1:0]  step_reg;
    logic [cr422_pkg::ROWS_W-1:0]  prior_reg;
    logic [cr422_pkg::ROWS_W-1:0]  rows_seen_reg;
    logic                          out_valid_reg;
    cr422_pkg::out_item_t          out_item_reg;

    logic                          in_acc;
    logic                          start_eff;
    logic [cr422_pkg::ROWS_W-1:0]  prior;
    logic [cr422_pkg::ROWS_W:0]    reach;
    logic                          emit;
    logic                          slot_ok;
    logic                          go;
    logic                          advance;
    logic                          last;
    logic                          done;
    cr422_pkg::cell_ctrl_t         ctrl;
    cr422_pkg::sample_t            shift_src;
    cr422_pkg::window_t            window;
    cr422_pkg::sample_t            fir_out;

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign start_eff = in_ch.payload.column_start || (rows_seen_reg == '0);
    assign prior     = start_eff ? '0 : rows_seen_reg;
    assign reach     = {1'b0, prior_reg} + {1'b0, step_reg};
    assign emit      = reach >= {1'b0, cr422_pkg::ROWS_FULL};
    assign slot_ok   = !out_valid_reg || out_ch.ready;
    assign go        = active_reg && (!emit || slot_ok);
    assign advance   = go && (!emit || half_reg);
    assign last      = (step_reg == cr422_pkg::LAST_STEP) || !end_reg;
    assign done      = advance && last;
    assign in_ch.ready = !active_reg || done;

    assign ctrl.fill  = in_acc && start_eff;
    assign ctrl.shift = (in_acc && !start_eff) || (advance && !last);
    assign shift_src  = in_acc ? in_ch.payload.in_sample : window[cr422_pkg::TAPS-1];

    for (genvar i = 0; i < cr422_pkg::TAPS; i++)
    begin : g_cells
        if (i == cr422_pkg::TAPS - 1)
        begin : g_head
            cr422_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .fill_value (in_ch.payload.in_sample),
                .neighbour  (shift_src),
                .value      (window[i])
            );
        end
        else
        begin : g_body
            cr422_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .fill_value (in_ch.payload.in_sample),
                .neighbour  (window[i+1]),
                .value      (window[i])
            );
        end
    end

    cr422_fir u_fir (
        .window (window),
        .odd    (half_reg),
        .result (fir_out)
    );

    // sequencer over the pair and flush steps of one request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            half_reg      <= 1'b0;
            end_reg       <= 1'b0;
            step_reg      <= '0;
            prior_reg     <= '0;
            rows_seen_reg <= '0;
        end
        else if (in_acc)
        begin
            active_reg <= in_ch.payload.column_end || (prior == cr422_pkg::ROWS_FULL);
            half_reg   <= 1'b0;
            end_reg    <= in_ch.payload.column_end;
            step_reg   <= '0;
            prior_reg  <= prior;
            if (in_ch.payload.column_end)
            begin
                rows_seen_reg <= '0;
            end
            else if (prior == cr422_pkg::ROWS_FULL)
            begin
                rows_seen_reg <= cr422_pkg::ROWS_FULL;
            end
            else
            begin
                rows_seen_reg <= prior + 1'b1;
            end
        end
        else if (go)
        begin
            if (emit && !half_reg)
            begin
                half_reg <= 1'b1;
            end
            else
            begin
                half_reg <= 1'b0;
                if (last)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            out_item_reg.out_sample  <= fir_out;
            out_item_reg.odd_row     <= half_reg;
            out_item_reg.run_end     <= half_reg && last;
            out_item_reg.column_done <= half_reg && end_reg &&
                                        (step_reg == cr422_pkg::LAST_STEP);
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.column_done |->
            out_item_reg.run_end && out_item_reg.odd_row)
        else $error("column_done without run_end on an odd row");

    a_end_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_ch.payload.column_end |=> active_reg && (rows_seen_reg == '0))
        else $error("column end request did not start the flush");

    a_no_accept_midrun: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !done |-> !in_ch.ready)
        else $error("request taken while results are still owed");
`endif

endmodule
